[hdl/cmfu_pkg.sv]
// ----------------------------------------------------------------------------
// cmfu_pkg
// shared widths, face codes and pipeline types of the cube map face unit
// ----------------------------------------------------------------------------
`default_nettype none

package cmfu_pkg;

	localparam int COORD_BITS = 24;
	localparam int UV_BITS    = 16;
	localparam int Q_BITS     = UV_BITS + 2;

	localparam logic [2:0] FACE_FRONT  = 3'd0;
	localparam logic [2:0] FACE_BACK   = 3'd1;
	localparam logic [2:0] FACE_LEFT   = 3'd2;
	localparam logic [2:0] FACE_RIGHT  = 3'd3;
	localparam logic [2:0] FACE_TOP    = 3'd4;
	localparam logic [2:0] FACE_BOTTOM = 3'd5;

	typedef struct packed {
		logic [2:0]            face;
		logic                  zero;
		logic [COORD_BITS-1:0] m;
		logic [COORD_BITS-1:0] ru;
		logic [COORD_BITS-1:0] rv;
		logic [Q_BITS-1:0]     qu;
		logic [Q_BITS-1:0]     qv;
	} div_t;

endpackage

`default_nettype wire

[hdl/cube_map_face_and_uv.sv]
// ----------------------------------------------------------------------------
// cube_map_face_and_uv
// cube face selection and face texture coordinates for a signed direction
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (lsb first)               tuser
//  s_*      in   dir_x[23:0] dir_y[47:24] dir_z[71:48]  -
//  m_*      out  face[2:0] coord_u[18:3] coord_v[34:19] zero_vector
//
// one request per cycle while the output is not stalled; the row of
// division cells yields one quotient bit per cell for u and v
// reset clears only the valid bits of every stage
// each stage holds its request while the next one is full and stalled, so
// bubbles are squeezed out and input is taken while a result waits
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_and_uv import cmfu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // dir_x, dir_y, dir_z
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // face, coord_u, coord_v, zero pad
	output logic [0:0]       m_tuser    // zero_vector
);

	logic               cv [0:UV_BITS];
	logic               cr [0:UV_BITS];
	div_t               cd [0:UV_BITS];
	logic [2:0]         face;
	logic [UV_BITS-1:0] coord_u, coord_v;
	logic               zero_vector;

	cmfu_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.dir_x     (s_tdata[23:0]),
		.dir_y     (s_tdata[47:24]),
		.dir_z     (s_tdata[71:48]),
		.out_valid (cv[0]),
		.out_ready (cr[0]),
		.out_data  (cd[0])
	);

	for (genvar i = 0; i < UV_BITS; i++) begin : g_cell
		cmfu_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (cr[i]),
			.in_data   (cd[i]),
			.out_valid (cv[i+1]),
			.out_ready (cr[i+1]),
			.out_data  (cd[i+1])
		);
	end

	cmfu_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cv[UV_BITS]),
		.in_ready    (cr[UV_BITS]),
		.in_data     (cd[UV_BITS]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.face        (face),
		.coord_u     (coord_u),
		.coord_v     (coord_v),
		.zero_vector (zero_vector)
	);

	assign m_tdata = {5'd0, coord_v, coord_u, face};
	assign m_tuser = zero_vector;

endmodule

`default_nettype wire

[hdl/cmfu_select.sv]
// ----------------------------------------------------------------------------
// cmfu_select
// major axis and face choice, numerator offset and first two quotient bits
// ----------------------------------------------------------------------------
`default_nettype none

module cmfu_select import cmfu_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] dir_x,
	input  wire logic signed [COORD_BITS-1:0] dir_y,
	input  wire logic signed [COORD_BITS-1:0] dir_z,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output div_t                              out_data
);

	logic [COORD_BITS-1:0] ax, ay, az;
	logic                  x_maj, y_maj;
	logic                  x_pos, y_pos, z_pos;
	logic [COORD_BITS:0]   xe, ye, ze;
	logic [2:0]            face_c;
	logic [COORD_BITS-1:0] m_c;
	logic [COORD_BITS:0]   nu_c, nv_c;

	logic                  valid_s1, zero_s1;
	logic [2:0]            face_s1;
	logic [COORD_BITS-1:0] m_s1;
	logic [COORD_BITS:0]   nu_s1, nv_s1;

	logic                  valid_s2, zero_s2;
	logic [2:0]            face_s2;
	logic [COORD_BITS-1:0] m_s2;
	logic [COORD_BITS:0]   au_s2, av_s2;

	logic                  valid_s3;
	div_t                  data_s3;

	logic                  rdy_s1, rdy_s2, rdy_s3;

	logic [COORD_BITS:0]   m_ext, m_dbl;
	logic                  bu1, bu0, bv1, bv0;
	logic [COORD_BITS:0]   ru_c, rv_c;
	div_t                  pre_c;

	assign rdy_s3   = !valid_s3 || out_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// magnitudes and major axis
	always_comb begin
		ax = dir_x[COORD_BITS-1] ? (~dir_x + 1'b1) : dir_x;
		ay = dir_y[COORD_BITS-1] ? (~dir_y + 1'b1) : dir_y;
		az = dir_z[COORD_BITS-1] ? (~dir_z + 1'b1) : dir_z;
		x_pos = !dir_x[COORD_BITS-1] && (dir_x != '0);
		y_pos = !dir_y[COORD_BITS-1] && (dir_y != '0);
		z_pos = !dir_z[COORD_BITS-1] && (dir_z != '0);
		xe = {dir_x[COORD_BITS-1], dir_x};
		ye = {dir_y[COORD_BITS-1], dir_y};
		ze = {dir_z[COORD_BITS-1], dir_z};
		x_maj = (ax > ay) && (ax > az);
		y_maj = (ax <= ay) && (ay > az);
		if (x_maj) begin
			m_c  = ax;
			nv_c = -ye;
			if (x_pos) begin
				face_c = FACE_RIGHT;
				nu_c   = ze;
			end else begin
				face_c = FACE_LEFT;
				nu_c   = -ze;
			end
		end else if (y_maj) begin
			m_c  = ay;
			nu_c = xe;
			if (y_pos) begin
				face_c = FACE_TOP;
				nv_c   = -ze;
			end else begin
				face_c = FACE_BOTTOM;
				nv_c   = ze;
			end
		end else begin
			m_c  = az;
			nv_c = -ye;
			if (z_pos) begin
				face_c = FACE_FRONT;
				nu_c   = -xe;
			end else begin
				face_c = FACE_BACK;
				nu_c   = xe;
			end
		end
	end

	// first two quotient bits: numerator offset lies in [0, 2m]
	always_comb begin
		m_ext = {1'b0, m_s2};
		m_dbl = {m_s2, 1'b0};
		bu1   = (au_s2 == m_dbl);
		bv1   = (av_s2 == m_dbl);
		bu0   = !bu1 && (au_s2 >= m_ext);
		bv0   = !bv1 && (av_s2 >= m_ext);
		ru_c  = bu1 ? '0 : (bu0 ? (au_s2 - m_ext) : au_s2);
		rv_c  = bv1 ? '0 : (bv0 ? (av_s2 - m_ext) : av_s2);
		pre_c.face = face_s2;
		pre_c.zero = zero_s2;
		pre_c.m    = m_s2;
		pre_c.ru   = ru_c[COORD_BITS-1:0];
		pre_c.rv   = rv_c[COORD_BITS-1:0];
		pre_c.qu   = {{(Q_BITS-2){1'b0}}, bu1, bu0};
		pre_c.qv   = {{(Q_BITS-2){1'b0}}, bv1, bv0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			face_s1 <= face_c;
			zero_s1 <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
			m_s1    <= m_c;
			nu_s1   <= nu_c;
			nv_s1   <= nv_c;
		end
		if (rdy_s2 && valid_s1) begin
			face_s2 <= face_s1;
			zero_s2 <= zero_s1;
			m_s2    <= m_s1;
			au_s2   <= nu_s1 + {1'b0, m_s1};
			av_s2   <= nv_s1 + {1'b0, m_s1};
		end
		if (rdy_s3 && valid_s2) begin
			data_s3 <= pre_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

`default_nettype wire

[hdl/cmfu_div_cell.sv]
// ----------------------------------------------------------------------------
// cmfu_div_cell
// one restoring division step for both coordinates, one quotient bit each
// ----------------------------------------------------------------------------
`default_nettype none

module cmfu_div_cell import cmfu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire div_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output div_t      out_data
);

	logic                valid_q;
	div_t                data_q;
	div_t                step_c;
	logic [COORD_BITS:0] m_ext, ru2, rv2, du, dv;
	logic                bu, bv;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		m_ext  = {1'b0, in_data.m};
		ru2    = {in_data.ru, 1'b0};
		rv2    = {in_data.rv, 1'b0};
		bu     = (ru2 >= m_ext);
		bv     = (rv2 >= m_ext);
		du     = bu ? (ru2 - m_ext) : ru2;
		dv     = bv ? (rv2 - m_ext) : rv2;
		step_c = in_data;
		step_c.ru = du[COORD_BITS-1:0];
		step_c.rv = dv[COORD_BITS-1:0];
		step_c.qu = {in_data.qu[Q_BITS-2:0], bu};
		step_c.qv = {in_data.qv[Q_BITS-2:0], bv};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= step_c;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

[hdl/cmfu_round.sv]
// ----------------------------------------------------------------------------
// cmfu_round
// round half up, saturation, zero vector override and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cmfu_round import cmfu_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire div_t         in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [2:0]        face,
	output logic [UV_BITS-1:0] coord_u,
	output logic [UV_BITS-1:0] coord_v,
	output logic              zero_vector
);

	logic               valid_q, zero_q;
	logic [2:0]         face_q;
	logic [UV_BITS-1:0] u_q, v_q;
	logic [Q_BITS:0]    su, sv;
	logic [UV_BITS-1:0] u_c, v_c;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		su = {1'b0, in_data.qu} + 1'b1;
		sv = {1'b0, in_data.qv} + 1'b1;
		u_c = su[UV_BITS+1] ? '1 : su[UV_BITS:1];
		v_c = sv[UV_BITS+1] ? '1 : sv[UV_BITS:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			zero_q <= in_data.zero;
			if (in_data.zero) begin
				face_q <= FACE_BACK;
				u_q    <= {1'b1, {(UV_BITS-1){1'b0}}};
				v_q    <= {1'b1, {(UV_BITS-1){1'b0}}};
			end else begin
				face_q <= in_data.face;
				u_q    <= u_c;
				v_q    <= v_c;
			end
		end
	end

	assign out_valid   = valid_q;
	assign face        = face_q;
	assign coord_u     = u_q;
	assign coord_v     = v_q;
	assign zero_vector = zero_q;

endmodule

`default_nettype wire
